### rtl/bgti_pkg.sv
// Shared types and constants of the bilinear grid table interpolator.
package bgti_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;
  localparam int ACC_W        = 98;
  localparam int DVS_W        = 64;
  localparam int CNT_W        = 6;

  typedef enum logic [1:0] {
    ACT_QUERY = 2'd0,
    ACT_ROW   = 2'd1,
    ACT_COL   = 2'd2,
    ACT_GRID  = 2'd3
  } action_e;

  typedef enum logic {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_CLAMP,
    ST_SCAN0,
    ST_SCAN,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_G4,
    ST_DMAG,
    ST_DMAG2,
    ST_TERM,
    ST_DIV,
    ST_DIVW
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [31:0] write_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               zero_cell;
  } out_t;

endpackage

### rtl/bgti_div.sv
// Restoring divider that produces one quotient bit per cycle.
module bgti_div #(
  parameter int NW = bgti_pkg::ACC_W,
  parameter int DW = bgti_pkg::DVS_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int CNW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CNW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   shifted;
  logic          fits;
  logic [DW:0]   diff;

  assign shifted = {rem_q, num_q[NW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      num_q <= {num_q[NW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

### rtl/bilinear_grid_table_interp.sv
// Top level of the bilinear grid table interpolator.
// Writes return nothing; busy_o stays low.
// A query holds busy_o through the two breakpoint scans over nl and nc, the counts in use
// (2..32), and through the 98-step divider, which a zero-area cell skips; its result strobe
// comes as busy_o falls, and a new item is accepted only while busy_o is low.
// Reset clears control state and sets both counts to 2; tables stay unset.
module bilinear_grid_table_interp #(
  parameter int MAX_ROWS = bgti_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bgti_pkg::DEF_MAX_COLS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  bgti_pkg::in_t              in_item_i,
  output logic                       done_o,
  output bgti_pkg::out_t             result_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [bgti_pkg::CNT_W-1:0] cfg_data_i
);

  import bgti_pkg::*;

  localparam int BD   = MAX_ROWS + MAX_COLS;
  localparam int BAW  = $clog2(BD);
  localparam int GD   = MAX_ROWS * MAX_COLS;
  localparam int GAW  = $clog2(GD);
  localparam int MAXN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int KW   = $clog2(MAXN + 1);

  function automatic logic [BAW-1:0] baddr(input logic dim, input logic [KW-1:0] k);
    return dim ? BAW'(MAX_ROWS + int'(k)) : BAW'(int'(k));
  endfunction

  function automatic logic [GAW-1:0] gaddr(input logic [KW-1:0] r, input logic [KW-1:0] c);
    return GAW'(int'(r) + MAX_ROWS * int'(c));
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] n;
    n = -v;
    return v[31] ? n : v;
  endfunction

  state_e state_q, state_d;

  logic [CNT_W-1:0] row_count_q, col_count_q;
  logic [KW-1:0]    nl, nc, n_cur;
  logic             d_q;
  logic [KW-1:0]    k_q;
  logic signed [31:0] p_q [2];
  logic signed [31:0] lo_q [2];
  logic signed [31:0] hi_q [2];
  logic [KW-1:0]    idx_q [2];
  logic signed [31:0] first_q, prev_q, cur, p_clamp;
  logic             hit;
  logic signed [31:0] c_q [4];
  logic signed [32:0] da_q [2];
  logic signed [32:0] db_q [2];
  logic signed [32:0] dd_q [2];
  logic [63:0]      dmag_q;
  logic [1:0]       term_q;
  logic [1:0]       step_q;
  logic [31:0]      p1hi_q;
  logic [63:0]      lo_prod_q;
  logic [63:0]      prod_q;
  logic [31:0]      mul_a, mul_b;
  logic signed [ACC_W-1:0] acc_q;
  logic [95:0]      tsum;
  logic [ACC_W-1:0] tval;
  logic             tneg;
  logic signed [32:0] t_dx, t_dy;
  logic signed [31:0] t_c;

  logic [31:0]      bmem [BD];
  logic [31:0]      gmem [GD];
  logic             bwe, bre, gwe, gre;
  logic [BAW-1:0]   bwa, bra;
  logic [GAW-1:0]   gwa, gra;
  logic [31:0]      brd_q, grd_q;

  logic             div_start, div_done;
  logic [ACC_W-1:0] div_num, div_q;
  logic             res_neg;
  logic [ACC_W-1:0] limit;
  logic [ACC_W-1:0] q_sat;
  logic [31:0]      q_neg;

  logic             accept, is_query;
  logic             done_q;
  out_t             result_q;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign is_query = in_item_i.action == ACT_QUERY;

  assign nl = (row_count_q < CNT_W'(2)) ? KW'(2) :
              (int'(row_count_q) > MAX_ROWS) ? KW'(MAX_ROWS) : KW'(row_count_q);
  assign nc = (col_count_q < CNT_W'(2)) ? KW'(2) :
              (int'(col_count_q) > MAX_COLS) ? KW'(MAX_COLS) : KW'(col_count_q);
  assign n_cur = d_q ? nc : nl;

  assign cur     = signed'(brd_q);
  assign p_clamp = (p_q[d_q] < first_q) ? first_q : (p_q[d_q] > cur) ? cur : p_q[d_q];
  assign hit     = (cur >= p_q[d_q] && p_q[d_q] >= prev_q) || (k_q == n_cur - KW'(2));

  assign t_dx = term_q[0] ? db_q[0] : da_q[0];
  assign t_dy = term_q[1] ? db_q[1] : da_q[1];
  assign t_c  = c_q[term_q];
  assign tneg = t_c[31] ^ t_dx[32] ^ t_dy[32];
  assign tsum = {prod_q, 32'd0} + {32'd0, lo_prod_q};
  assign tval = ACC_W'(tsum);

  assign div_num = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign res_neg = acc_q[ACC_W-1] ^ dd_q[0][32] ^ dd_q[1][32];
  assign limit   = res_neg ? ACC_W'(33'h080000000) : ACC_W'(33'h07fffffff);
  assign q_sat   = (div_q > limit) ? limit : div_q;
  assign q_neg   = -q_sat[31:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && is_query) state_d = ST_FIRST;
      ST_FIRST: state_d = ST_LAST;
      ST_LAST:  state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_SCAN0;
      ST_SCAN0: state_d = ST_SCAN;
      ST_SCAN:  if (hit) state_d = d_q ? ST_G0 : ST_FIRST;
      ST_G0: begin
        if (lo_q[0] == hi_q[0] || lo_q[1] == hi_q[1]) state_d = ST_IDLE;
        else state_d = ST_G1;
      end
      ST_G1:    state_d = ST_G2;
      ST_G2:    state_d = ST_G3;
      ST_G3:    state_d = ST_G4;
      ST_G4:    state_d = ST_DMAG;
      ST_DMAG:  state_d = ST_DMAG2;
      ST_DMAG2: state_d = ST_TERM;
      ST_TERM:  if (step_q == 2'd3 && term_q == 2'd3) state_d = ST_DIV;
      ST_DIV:   state_d = ST_DIVW;
      ST_DIVW:  if (div_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Memory, multiplier and divider controls.
  always_comb begin
    bwe       = 1'b0;
    bwa       = '0;
    gwe       = 1'b0;
    gwa       = gaddr(KW'(in_item_i.row_index), KW'(in_item_i.col_index));
    bre       = 1'b0;
    bra       = '0;
    gre       = 1'b0;
    gra       = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.action == ACT_ROW && int'(in_item_i.row_index) < MAX_ROWS) begin
            bwe = 1'b1;
            bwa = baddr(1'b0, KW'(in_item_i.row_index));
          end
          if (in_item_i.action == ACT_COL && int'(in_item_i.col_index) < MAX_COLS) begin
            bwe = 1'b1;
            bwa = baddr(1'b1, KW'(in_item_i.col_index));
          end
          gwe = in_item_i.action == ACT_GRID && int'(in_item_i.row_index) < MAX_ROWS &&
                int'(in_item_i.col_index) < MAX_COLS;
        end
      end
      ST_FIRST, ST_CLAMP: begin
        bre = 1'b1;
        bra = baddr(d_q, '0);
      end
      ST_LAST: begin
        bre = 1'b1;
        bra = baddr(d_q, n_cur - KW'(1));
      end
      ST_SCAN0: begin
        bre = 1'b1;
        bra = baddr(d_q, KW'(1));
      end
      ST_SCAN: begin
        bre = !hit;
        bra = baddr(d_q, k_q + KW'(2));
      end
      ST_G0: begin
        gre = 1'b1;
        gra = gaddr(idx_q[0], idx_q[1]);
      end
      ST_G1: begin
        gre = 1'b1;
        gra = gaddr(idx_q[0] + KW'(1), idx_q[1]);
      end
      ST_G2: begin
        gre = 1'b1;
        gra = gaddr(idx_q[0], idx_q[1] + KW'(1));
      end
      ST_G3: begin
        gre = 1'b1;
        gra = gaddr(idx_q[0] + KW'(1), idx_q[1] + KW'(1));
      end
      ST_DMAG: begin
        mul_a = mag33(dd_q[0]);
        mul_b = mag33(dd_q[1]);
      end
      ST_TERM: begin
        case (step_q)
          2'd0: begin
            mul_a = mag32(t_c);
            mul_b = mag33(t_dx);
          end
          2'd1: begin
            mul_a = prod_q[31:0];
            mul_b = mag33(t_dy);
          end
          2'd2: begin
            mul_a = p1hi_q;
            mul_b = mag33(t_dy);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_DIV:  div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bwe) bmem[bwa] <= in_item_i.write_value;
    if (bre) brd_q <= bmem[bra];
  end

  always_ff @(posedge clk_i) begin
    if (gwe) gmem[gwa] <= in_item_i.write_value;
    if (gre) grd_q <= gmem[gra];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_count_q <= CNT_W'(2);
      col_count_q <= CNT_W'(2);
      d_q         <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROW_COUNT: row_count_q <= cfg_data_i;
          CFG_COL_COUNT: col_count_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (state_q == ST_IDLE) d_q <= 1'b0;
      else if (state_q == ST_SCAN && hit) d_q <= 1'b1;
      if ((state_q == ST_G0 && state_d == ST_IDLE) || (state_q == ST_DIVW && div_done)) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        p_q[0] <= in_item_i.query_x;
        p_q[1] <= in_item_i.query_y;
      end
      ST_LAST:  first_q <= cur;
      ST_CLAMP: begin
        p_q[d_q] <= p_clamp;
        k_q      <= '0;
      end
      ST_SCAN0: prev_q <= cur;
      ST_SCAN: begin
        if (hit) begin
          lo_q[d_q]  <= prev_q;
          hi_q[d_q]  <= cur;
          idx_q[d_q] <= k_q;
        end else begin
          prev_q <= cur;
          k_q    <= k_q + KW'(1);
        end
      end
      ST_G0: begin
        result_q.interp_value <= '0;
        result_q.zero_cell    <= 1'b1;
      end
      ST_G1: c_q[0] <= signed'(grd_q);
      ST_G2: c_q[1] <= signed'(grd_q);
      ST_G3: c_q[2] <= signed'(grd_q);
      ST_G4: begin
        c_q[3] <= signed'(grd_q);
        for (int d = 0; d < 2; d++) begin
          da_q[d] <= {hi_q[d][31], hi_q[d]} - {p_q[d][31], p_q[d]};
          db_q[d] <= {p_q[d][31], p_q[d]} - {lo_q[d][31], lo_q[d]};
          dd_q[d] <= {hi_q[d][31], hi_q[d]} - {lo_q[d][31], lo_q[d]};
        end
      end
      ST_DMAG2: begin
        dmag_q <= prod_q;
        term_q <= '0;
        step_q <= '0;
        acc_q  <= '0;
      end
      ST_TERM: begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd1) p1hi_q <= prod_q[63:32];
        if (step_q == 2'd2) lo_prod_q <= prod_q;
        if (step_q == 2'd3) begin
          acc_q  <= tneg ? acc_q - signed'(tval) : acc_q + signed'(tval);
          term_q <= term_q + 2'd1;
        end
      end
      ST_DIVW: begin
        result_q.interp_value <= res_neg ? signed'(q_neg) : signed'(q_sat[31:0]);
        result_q.zero_cell    <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  bgti_div #(
    .NW(ACC_W),
    .DW(DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (dmag_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign busy_o   = state_q != ST_IDLE;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### rtl/bgti_checker.sv
// Port-level checks of the bilinear grid table interpolator and their bind.
module bgti_assert (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input bgti_pkg::in_t              in_item_i,
  input logic                       done_o,
  input bgti_pkg::out_t             result_o,
  input logic                       cfg_we_i,
  input logic                       cfg_idx_i,
  input logic [bgti_pkg::CNT_W-1:0] cfg_data_i
);

  import bgti_pkg::*;

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_item_i.action == ACT_QUERY) |=> busy_o)
    else $error("query transfer did not raise busy");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_item_i.action != ACT_QUERY) |=> (!busy_o && !done_o))
    else $error("write transfer changed busy or gave a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && $past(busy_o)))
    else $error("result strobe outside the end of a query");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.zero_cell) |-> (result_o.interp_value == 0))
    else $error("zero-area cell with nonzero value");

endmodule

bind bilinear_grid_table_interp bgti_assert u_bgti_checker (.*);
